@@ design/bdt_pkg.sv @@
// Shared widths, constants, types and the month table for the calendar time converter.
// Depends on nothing; every other design file imports it.
`default_nettype none

package bdt_pkg;

	localparam int YEAR_W  = 16;
	localparam int FIELD_W = 8;
	localparam int IN_BUS_W  = 56;
	localparam int OUT_W   = 43;
	localparam int OUT_BUS_W = 48;

	localparam int D_W     = 17;
	localparam int HMS_W   = 20;
	localparam int DAYS_W  = 16;
	localparam int YSEC_W  = 41;
	localparam int DSEC_W  = 32;

	localparam int MON_BIAS    = 132;
	localparam int MON_RECIP   = 171;
	localparam int MON_SHIFT   = 11;
	localparam int CYCLE_DAYS  = 97;
	localparam int CENT_DAYS   = 24;
	localparam int CYCLE_YEARS = 400;
	localparam int CYCLE_BIAS  = 83;
	localparam int CYCLE_RECIP = 41943;
	localparam int CYCLE_SHIFT = 24;
	localparam int BASE_YEAR   = 100;
	localparam int SECS_PER_YEAR = 31536000;
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_AT_2000  = 946684800;
	localparam int MARCH         = 2;

	typedef struct packed {
		logic [7:0]                q;
		logic [8:0]                rem;
		logic [3:0]                mon;
		logic signed [FIELD_W-1:0] mday;
	} bdt_year_t;

	function automatic logic [8:0] month_start(input logic [3:0] mon);
		logic [8:0] r;
		unique case (mon)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/bdt_leap_days.sv @@
// Day count from the epoch of the year cycle, centuries and leap years, plus month and day.
// Depends on bdt_pkg for the year record type and the month table.
`default_nettype none

module bdt_leap_days
	import bdt_pkg::*;
(
	input  bdt_year_t                  yr,
	output logic signed [DAYS_W-1:0]   days
);

	logic signed [8:0]  cycles;
	logic [1:0]         cent;
	logic [8:0]         r2_full;
	logic [6:0]         r2;
	logic               leap;
	logic               leap_add;
	logic [8:0]         mdays;

	always_comb begin
		cycles = $signed({1'b0, yr.q}) - 9'(CYCLE_BIAS);
		if (yr.rem >= 9'd300) begin
			cent = 2'd3;
		end else if (yr.rem >= 9'd200) begin
			cent = 2'd2;
		end else if (yr.rem >= 9'd100) begin
			cent = 2'd1;
		end else begin
			cent = 2'd0;
		end
		r2_full  = yr.rem - 9'({7'd0, cent} * 9'd100);
		r2       = r2_full[6:0];
		leap     = (yr.rem == 9'd0) || ((r2 != 7'd0) && (r2[1:0] == 2'd0));
		leap_add = leap && (yr.mon >= 4'(MARCH));
		mdays    = month_start(yr.mon);
		days     = DAYS_W'(cycles) * DAYS_W'(CYCLE_DAYS)
			+ DAYS_W'(CENT_DAYS) * $signed(DAYS_W'({14'd0, cent}))
			+ $signed(DAYS_W'({2'd0, r2[6:2]}))
			- $signed(DAYS_W'({15'd0, leap}))
			+ $signed(DAYS_W'(mdays))
			+ $signed(DAYS_W'({15'd0, leap_add}))
			+ DAYS_W'(yr.mday);
	end

endmodule

`default_nettype wire

@@ design/broken_down_time_to_unix_seconds_top.sv @@
// Top level of the calendar time to Unix seconds converter: six-stage pipeline.
// Depends on bdt_pkg and bdt_leap_days.
//
// Usage: each item on the s_axis channel is one broken-down calendar time; for
// each item the m_axis channel delivers one signed count of seconds since
// 1970-01-01 00:00:00 under the proleptic Gregorian calendar.
// Each item passes through the stage registers in order, and one item is taken every
// cycle while the receiver does not stall. The stages fold the month into the year,
// estimate the 400-year cycle count by a reciprocal multiply, correct it, count days
// and year seconds, scale days to seconds and add up the result.
// Every stage has its own valid bit and is loaded whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and input
// is still taken until the pipeline is full. A stalled result holds its value.
// Reset empties all stages; no result is valid after reset.
`default_nettype none

module broken_down_time_to_unix_seconds_top
	import bdt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// year_since_1900[15:0], month_index[23:16], day_of_month[31:24],
	// hour_value[39:32], minute_value[47:40], second_value[55:48]
	input  logic [IN_BUS_W-1:0]  s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// unix_seconds[42:0], zero fill [47:43]
	output logic [OUT_BUS_W-1:0] m_axis_tdata
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || m_axis_tready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: month folding, year offset, time of day.
	logic signed [YEAR_W-1:0]  in_year;
	logic signed [FIELD_W-1:0] in_mon, in_mday, in_hour, in_min, in_sec;
	logic [8:0]                mon_x;
	logic [16:0]               mon_prod;
	logic [4:0]                mon_q;
	logic [8:0]                mon_r;
	logic signed [D_W-1:0]     year_adj, d_c;
	logic [D_W-1:0]            e_c;
	logic signed [HMS_W-1:0]   hms_c;

	always_comb begin
		in_year  = s_axis_tdata[15:0];
		in_mon   = s_axis_tdata[23:16];
		in_mday  = s_axis_tdata[31:24];
		in_hour  = s_axis_tdata[39:32];
		in_min   = s_axis_tdata[47:40];
		in_sec   = s_axis_tdata[55:48];
		mon_x    = {in_mon[7], in_mon} + 9'(MON_BIAS);
		mon_prod = {8'd0, mon_x} * 17'(MON_RECIP);
		mon_q    = mon_prod[MON_SHIFT +: 5];
		mon_r    = mon_x - 9'({4'd0, mon_q} * 9'd12);
		year_adj = D_W'(in_year) + $signed({12'd0, mon_q}) - 17'sd11;
		d_c      = year_adj - D_W'(BASE_YEAR);
		e_c      = d_c + D_W'(CYCLE_YEARS * CYCLE_BIAS);
		hms_c    = HMS_W'(in_hour) * 20'sd3600 + HMS_W'(in_min) * 20'sd60
			+ HMS_W'(in_sec);
	end

	logic signed [D_W-1:0]     d_s1;
	logic [D_W-1:0]            e_s1;
	logic [3:0]                mon_s1;
	logic signed [FIELD_W-1:0] mday_s1;
	logic signed [HMS_W-1:0]   hms_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d_s1    <= d_c;
			e_s1    <= e_c;
			mon_s1  <= mon_r[3:0];
			mday_s1 <= in_mday;
			hms_s1  <= hms_c;
		end
	end

	// Stage 2: reciprocal multiply for the 400-year cycle count.
	logic [32:0]               prod_s2;
	logic signed [D_W-1:0]     d_s2;
	logic [D_W-1:0]            e_s2;
	logic [3:0]                mon_s2;
	logic signed [FIELD_W-1:0] mday_s2;
	logic signed [HMS_W-1:0]   hms_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			prod_s2 <= {16'd0, e_s1} * 33'(CYCLE_RECIP);
			d_s2    <= d_s1;
			e_s2    <= e_s1;
			mon_s2  <= mon_s1;
			mday_s2 <= mday_s1;
			hms_s2  <= hms_s1;
		end
	end

	// Stage 3: the estimate is low by at most one; correct it.
	logic [8:0]  q_est;
	logic [16:0] q400;
	logic [16:0] r0;
	logic        r_ge;
	logic [7:0]  q_c;
	logic [8:0]  rem_c;

	always_comb begin
		q_est = prod_s2[CYCLE_SHIFT +: 9];
		q400  = {8'd0, q_est} * 17'(CYCLE_YEARS);
		r0    = e_s2 - q400;
		r_ge  = r0 >= 17'(CYCLE_YEARS);
		q_c   = q_est[7:0] + 8'(r_ge);
		rem_c = r_ge ? 9'(r0 - 17'(CYCLE_YEARS)) : r0[8:0];
	end

	bdt_year_t                 yr_s3;
	logic signed [D_W-1:0]     d_s3;
	logic signed [HMS_W-1:0]   hms_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			yr_s3.q    <= q_c;
			yr_s3.rem  <= rem_c;
			yr_s3.mon  <= mon_s2;
			yr_s3.mday <= mday_s2;
			d_s3       <= d_s2;
			hms_s3     <= hms_s2;
		end
	end

	// Stage 4: day count and whole-year seconds.
	logic signed [DAYS_W-1:0] days_c;
	logic signed [YSEC_W-1:0] d_ext;

	bdt_leap_days u_leap_days (
		.yr   (yr_s3),
		.days (days_c)
	);

	assign d_ext = YSEC_W'(d_s3);

	logic signed [DAYS_W-1:0] days_s4;
	logic signed [YSEC_W-1:0] ysec_s4;
	logic signed [HMS_W-1:0]  hms_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			days_s4 <= days_c;
			ysec_s4 <= d_ext * YSEC_W'(SECS_PER_YEAR);
			hms_s4  <= hms_s3;
		end
	end

	// Stage 5: days to seconds.
	logic signed [DSEC_W-1:0] days_ext;
	logic signed [DSEC_W-1:0] dsec_s5;
	logic signed [YSEC_W-1:0] ysec_s5;
	logic signed [HMS_W-1:0]  hms_s5;

	assign days_ext = DSEC_W'(days_s4);

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			dsec_s5 <= days_ext * DSEC_W'(SECS_PER_DAY);
			ysec_s5 <= ysec_s4;
			hms_s5  <= hms_s4;
		end
	end

	// Stage 6: final sum, held as the output register.
	logic signed [OUT_W-1:0] secs_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			secs_s6 <= OUT_W'(ysec_s5) + OUT_W'(dsec_s5) + OUT_W'(hms_s5)
				+ OUT_W'(SECS_AT_2000);
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {(OUT_BUS_W - OUT_W)'(0), secs_s6};

`ifndef NO_ASSERTIONS
	a_mon_folded: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (mon_s1 < 4'd12))
		else $error("folded month out of range");

	a_rem_corrected: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (yr_s3.rem < 9'(CYCLE_YEARS)))
		else $error("cycle remainder not corrected");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> (v_s1 && $stable(d_s1) && $stable(hms_s1)))
		else $error("stalled first-stage item lost or changed");

	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy_s4) |=> (v_s3 && $stable(yr_s3)))
		else $error("stalled third-stage item lost or changed");
`endif

endmodule

`default_nettype wire
